// ===== src/lmpp_pkg.sv =====
// Package for the LED matrix pixel plotter.
// Holds field widths, coordinate limits, shadow store geometry and shared types.
// Has no dependencies.
package lmpp_pkg;

	// Field widths of the plot and write transactions.
	localparam int X_W     = 6;
	localparam int Y_W     = 5;
	localparam int COL_W   = 2;
	localparam int CHIP_W  = 2;
	localparam int WADDR_W = 6;
	localparam int LADDR_W = 5;
	localparam int NIB_W   = 4;

	// Largest column and row that are plotted; anything beyond is dropped.
	localparam logic [X_W-1:0] COLUMN_LIMIT = 6'd31;
	localparam logic [Y_W-1:0] ROW_LIMIT    = 5'd15;

	// Shadow store: four chips of 64 nibbles each.
	localparam int MEM_DEPTH = 256;
	localparam int MEM_AW    = 8;

	// Decoded plot position, handed from the decoder to the sequencer.
	typedef struct packed {
		logic              in_range;
		logic [CHIP_W-1:0] chip;
		logic [LADDR_W-1:0] addr;
		logic [NIB_W-1:0]  mask;
	} plot_dec_t;

	// One chip RAM write as it goes out.
	typedef struct packed {
		logic [CHIP_W-1:0]  chip_index;
		logic [WADDR_W-1:0] word_address;
		logic [NIB_W-1:0]   nibble;
		logic               last_write;
	} wr_item_t;

endpackage

// ===== src/lmpp_ifs.sv =====
// Handshake interfaces for the LED matrix pixel plotter.
// lmpp_plot_if carries plot requests, lmpp_wr_if carries chip RAM writes.
// Depends on lmpp_pkg.
interface lmpp_plot_if;
	import lmpp_pkg::*;

	logic             valid;
	logic             ready;
	logic [X_W-1:0]   x_coord;
	logic [Y_W-1:0]   y_coord;
	logic [COL_W-1:0] colour;

	modport source (output valid, x_coord, y_coord, colour, input ready);
	modport sink (input valid, x_coord, y_coord, colour, output ready);
endinterface

interface lmpp_wr_if;
	import lmpp_pkg::*;

	logic               valid;
	logic               ready;
	logic [CHIP_W-1:0]  chip_index;
	logic [WADDR_W-1:0] word_address;
	logic [NIB_W-1:0]   nibble;
	logic               last_write;

	modport source (output valid, chip_index, word_address, nibble, last_write, input ready);
	modport sink (input valid, chip_index, word_address, nibble, last_write, output ready);
endinterface

// ===== src/lmpp_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Has no dependencies.
module lmpp_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/lmpp_decode.sv =====
// Plot decoder: range check, chip select, nibble address and bit mask.
// Depends on lmpp_pkg.
module lmpp_decode (
	input  logic [lmpp_pkg::X_W-1:0] x_coord,
	input  logic [lmpp_pkg::Y_W-1:0] y_coord,
	output lmpp_pkg::plot_dec_t      dec
);
	import lmpp_pkg::*;

	// Chips sit 2x2; each chip holds 16 columns of two nibbles, four rows per nibble.
	always_comb begin
		dec.in_range = (x_coord <= COLUMN_LIMIT) && (y_coord <= ROW_LIMIT);
		dec.chip     = {y_coord[3], x_coord[4]};
		dec.addr     = {x_coord[3:0], y_coord[2]};
		dec.mask     = 4'b1000 >> y_coord[1:0];
	end

endmodule

// ===== src/lmpp_outq.sv =====
// Two-entry output queue that decouples the sequencer from the write channel.
// Depends on lmpp_pkg and lmpp_wr_if.
module lmpp_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lmpp_pkg::wr_item_t  push_item,
	output logic                space,
	lmpp_wr_if.source           wr
);
	import lmpp_pkg::*;

	wr_item_t   entry_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign space = (count_q != 2'd2);
	assign pop   = wr.valid && wr.ready;

	// Head entry drives the channel.
	always_comb begin
		wr.valid        = (count_q != 2'd0);
		wr.chip_index   = entry_q[rptr_q].chip_index;
		wr.word_address = entry_q[rptr_q].word_address;
		wr.nibble       = entry_q[rptr_q].nibble;
		wr.last_write   = entry_q[rptr_q].last_write;
	end

	// Entry storage carries no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== src/led_matrix_pixel_plotter.sv =====
// Channel   Dir  Payload                                        Transaction
// plot      in   x_coord[6], y_coord[5], colour[2]              valid && ready
// wr        out  chip_index[2], word_address[6], nibble[4],     valid && ready
//                last_write[1]
//
// A plot in range does a green read-modify-write, then a red one, both
// through the single write port and single read port of the shadow RAM.
// A new plot is taken in the cycle the red write of the previous one retires.
// After reset the shadow RAM is cleared one entry a cycle, with plot ready held
// low. A full two-entry output queue stalls the sequencer in place.
// Out-of-range plots are taken and give no write.
//
// Top level of the LED matrix pixel plotter.
// Depends on lmpp_pkg, lmpp_ifs, lmpp_ram, lmpp_decode and lmpp_outq.
module led_matrix_pixel_plotter (
	input  logic        clk,
	input  logic        arst_n,
	lmpp_plot_if.sink   plot,
	lmpp_wr_if.source   wr
);
	import lmpp_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_GREEN = 2'd2;
	localparam logic [1:0] ST_RED   = 2'd3;

	logic [1:0]         state_q;
	logic [1:0]         state_nxt;
	logic [MEM_AW-1:0]  clr_q;
	plot_dec_t          dec;
	logic [CHIP_W-1:0]  chip_q;
	logic [LADDR_W-1:0] addr_q;
	logic [NIB_W-1:0]   mask_q;
	logic [COL_W-1:0]   colour_q;
	logic               space;
	logic               accept;
	logic               advance;
	logic               set_bit;
	logic [NIB_W-1:0]   new_nib;
	logic               ram_we;
	logic [MEM_AW-1:0]  ram_waddr;
	logic [NIB_W-1:0]   ram_wdata;
	logic [MEM_AW-1:0]  ram_raddr;
	logic [NIB_W-1:0]   ram_rdata;
	logic               push;
	wr_item_t           push_item;
	logic [MEM_AW-1:0]  green_idx_q;
	logic [MEM_AW-1:0]  red_idx_q;
	logic [MEM_AW-1:0]  green_idx_in;

	lmpp_decode u_decode (
		.x_coord (plot.x_coord),
		.y_coord (plot.y_coord),
		.dec     (dec)
	);

	lmpp_ram #(
		.WIDTH (NIB_W),
		.DEPTH (MEM_DEPTH)
	) u_shadow (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lmpp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.space     (space),
		.wr        (wr)
	);

	// Handshake: a plot enters when idle or as the red write retires.
	assign plot.ready = (state_q == ST_IDLE) || ((state_q == ST_RED) && space);
	assign accept     = plot.valid && plot.ready;
	assign advance    = ((state_q == ST_GREEN) || (state_q == ST_RED)) && space;

	// Shadow RAM indexes: chip, plane bit, nibble address.
	assign green_idx_in = {dec.chip, 1'b0, dec.addr};
	assign green_idx_q  = {chip_q, 1'b0, addr_q};
	assign red_idx_q    = {chip_q, 1'b1, addr_q};

	// Modify the nibble read from the shadow RAM for the current plane.
	always_comb begin
		set_bit = (state_q == ST_GREEN) ? colour_q[0] : colour_q[1];
		new_nib = set_bit ? (ram_rdata | mask_q) : (ram_rdata & ~mask_q);
	end

	// Read address: held while stalled so the registered data stays put.
	always_comb begin
		case (state_q)
			ST_GREEN: ram_raddr = advance ? red_idx_q : green_idx_q;
			ST_RED:   ram_raddr = advance ? green_idx_in : red_idx_q;
			default:  ram_raddr = green_idx_in;
		endcase
	end

	// Write port: clearing sweep, then write-back of each plane.
	always_comb begin
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_GREEN: begin
				ram_we    = advance;
				ram_waddr = green_idx_q;
				ram_wdata = new_nib;
			end
			ST_RED: begin
				ram_we    = advance;
				ram_waddr = red_idx_q;
				ram_wdata = new_nib;
			end
			default: begin
				ram_we    = 1'b0;
				ram_waddr = clr_q;
				ram_wdata = new_nib;
			end
		endcase
	end

	// Result transaction pushed with each write-back.
	always_comb begin
		push                   = advance;
		push_item.chip_index   = chip_q;
		push_item.word_address = {(state_q == ST_RED), addr_q};
		push_item.nibble       = new_nib;
		push_item.last_write   = (state_q == ST_RED);
	end

	// Next state of the sequencer.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == MEM_AW'(MEM_DEPTH - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && dec.in_range) begin
					state_nxt = ST_GREEN;
				end
			end
			ST_GREEN: begin
				if (advance) begin
					state_nxt = ST_RED;
				end
			end
			ST_RED: begin
				if (advance) begin
					state_nxt = (accept && dec.in_range) ? ST_GREEN : ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Plot held for its two write-backs.
	always_ff @(posedge clk) begin
		if (accept) begin
			chip_q   <= dec.chip;
			addr_q   <= dec.addr;
			mask_q   <= dec.mask;
			colour_q <= plot.colour;
		end
	end

`ifndef ASSERT_OFF
	// Nothing is taken or sent while the shadow RAM is being cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!plot.ready && !wr.valid))
		else $error("plot taken or write sent during clear sweep");

	// A write-back never targets the entry read in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q != ST_CLEAR)) |-> (ram_waddr != ram_raddr))
		else $error("shadow RAM read and write collide on one entry");

	// The green write of a plot is always followed by its red write.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !push_item.last_write) |=> (state_q == ST_RED))
		else $error("green write not followed by red write");

	// An out-of-range plot leaves the sequencer idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !dec.in_range) |=> (state_q == ST_IDLE))
		else $error("dropped plot started a write-back");
`endif

endmodule
